/* sv/tsgc_pkg.sv */
// shared types, register map and constants of the tempo synced gate clock
`default_nettype none

package tsgc_pkg;

  localparam logic [2:0] REG_TEMPO      = 3'd0;
  localparam logic [2:0] REG_RATE_MULT  = 3'd1;
  localparam logic [2:0] REG_PULSE_W    = 3'd2;
  localparam logic [2:0] REG_SAMPLE_HZ  = 3'd3;
  localparam logic [2:0] REG_SYNC_MODE  = 3'd4;
  localparam logic [2:0] REG_RUN_EN     = 3'd5;
  localparam logic [2:0] REG_USER_EN    = 3'd6;

  localparam int unsigned TEMPO_LO = 16;
  localparam int unsigned TEMPO_HI = 16000;
  localparam int unsigned RMULT_LO = 7;
  localparam int unsigned RMULT_HI = 8388608;
  localparam int unsigned PW_LO    = 66;
  localparam int unsigned PW_HI    = 65470;
  localparam int unsigned SR_LO    = 1;
  localparam int unsigned SR_HI    = 192000;

  localparam logic [13:0] TEMPO_RST = 14'd1920;
  localparam logic [23:0] RMULT_RST = 24'd65536;
  localparam logic [15:0] PW_RST    = 16'd32768;
  localparam logic [17:0] SR_RST    = 18'd48000;

  localparam logic signed [15:0] SYNC_HIGH_LVL = 16'sd16384;

  typedef struct packed {
    logic start;
    logic short_op;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [31:0] clamp_u32(input logic [31:0] v, input int unsigned lo,
                                            input int unsigned hi);
    logic [31:0] r;
    r = v;
    if (v < 32'(lo)) r = 32'(lo);
    else if (v > 32'(hi)) r = 32'(hi);
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/tsgc_div.sv */
// serial restoring divider, one quotient bit per cycle, keeps the low phase bits
`default_nettype none

module tsgc_div #(
  parameter int PHASE_BITS = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  tsgc_pkg::div_ctl_t                             ctl_i,
  input  logic [PHASE_BITS+17:0]                         dividend_i,
  input  logic [((COUNT_BITS > 24) ? COUNT_BITS : 24)-1:0] divisor_i,
  output tsgc_pkg::div_stat_t                            stat_o,
  output logic [PHASE_BITS-1:0]                          quot_o
);
  import tsgc_pkg::*;

  localparam int DW  = PHASE_BITS + 18;
  localparam int DVW = (COUNT_BITS > 24) ? COUNT_BITS : 24;
  localparam int IW  = $clog2(DW + 1);
  localparam logic [IW-1:0] SHORT_N = IW'(PHASE_BITS + 8);
  localparam logic [IW-1:0] LONG_N  = IW'(DW);

  logic [DW-1:0]         sh_q;
  logic [DVW-1:0]        rem_q, den_q, rem_d;
  logic [PHASE_BITS-1:0] quot_q;
  logic [IW-1:0]         iter_q;
  logic                  busy_q, done_q;
  logic [DVW:0]          trial, diff;
  logic                  ge;

  always_comb begin
    trial = {rem_q, sh_q[DW-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? diff[DVW-1:0] : trial[DVW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        iter_q <= ctl_i.short_op ? SHORT_N : LONG_N;
      end else if (busy_q) begin
        iter_q <= iter_q - 1'b1;
        if (iter_q == IW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      sh_q   <= dividend_i;
      den_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      sh_q   <= sh_q << 1;
      rem_q  <= rem_d;
      quot_q <= {quot_q[PHASE_BITS-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

`default_nettype wire

/* sv/tempo_sync_gate_clock_core.sv */
// top level of the tempo synced gate clock: registers, tick sequencer, phase accumulator
//
// One word in is one sample tick and gives one word out. A running tick recomputes the
// phase step with a shared serial divider that yields one quotient bit per cycle; with a
// measured sync period the divider runs a shorter operation than free running, and a
// stopped tick skips the divider. The input stalls while a tick is in work; a finished
// word waits in the output register while the next tick is taken.
`default_nettype none

module tempo_sync_gate_clock_core #(
  parameter int PHASE_BITS = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] sync_sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               gate_out_o,
  output logic               clock_active_o,
  output logic               sync_edge_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tsgc_pkg::*;

  localparam int DW  = PHASE_BITS + 18;
  localparam int DVW = (COUNT_BITS > 24) ? COUNT_BITS : 24;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [13:0] tempo_q;
  logic [23:0] rmult_q;
  logic [15:0] pw_q;
  logic [17:0] sr_q;
  logic        sync_mode_q, run_en_q, user_en_q;

  logic [37:0] prod_q;
  logic [23:0] sr60_q;

  logic [2:0]            state_q;
  logic signed [15:0]    x_q;
  logic [PHASE_BITS-1:0] phase_q;
  logic [COUNT_BITS-1:0] cnt_q, per_q;
  logic                  was_high_q;
  logic                  res_gate_q, res_active_q, res_edge_q;
  logic                  out_valid_q, gate_q, active_q, edge_q;

  logic                  cfg_wr;
  logic [2:0]            cfg_idx;
  logic [COUNT_BITS-1:0] cnt_inc, cnt_new, per_new;
  logic                  high, sync_rise, run;
  logic [PHASE_BITS+23:0] num_a;
  logic [PHASE_BITS+37:0] num_b;
  logic [DW-1:0]         dividend;
  logic [DVW-1:0]        divisor;
  logic [PHASE_BITS-1:0] quot, phase_sum, pw_cmp;
  div_ctl_t              div_ctl;
  div_stat_t             div_stat;
  logic                  push;
  logic                  tempo_wr;

  assign cfg_wr   = psel & penable & pwrite;
  assign cfg_idx  = paddr[4:2];
  assign tempo_wr = cfg_wr & (cfg_idx == REG_TEMPO);
  assign pready   = 1'b1;

  always_comb begin
    case (cfg_idx)
      REG_TEMPO:     prdata = 32'(tempo_q);
      REG_RATE_MULT: prdata = 32'(rmult_q);
      REG_PULSE_W:   prdata = 32'(pw_q);
      REG_SAMPLE_HZ: prdata = 32'(sr_q);
      REG_SYNC_MODE: prdata = 32'(sync_mode_q);
      REG_RUN_EN:    prdata = 32'(run_en_q);
      REG_USER_EN:   prdata = 32'(user_en_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_q     <= TEMPO_RST;
      rmult_q     <= RMULT_RST;
      pw_q        <= PW_RST;
      sr_q        <= SR_RST;
      sync_mode_q <= 1'b0;
      run_en_q    <= 1'b1;
      user_en_q   <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TEMPO:     tempo_q <= 14'(clamp_u32(32'(pwdata[13:0]), TEMPO_LO, TEMPO_HI));
        REG_RATE_MULT: rmult_q <= 24'(clamp_u32(32'(pwdata[23:0]), RMULT_LO, RMULT_HI));
        REG_PULSE_W:   pw_q    <= 16'(clamp_u32(32'(pwdata[15:0]), PW_LO, PW_HI));
        REG_SAMPLE_HZ: sr_q    <= 18'(clamp_u32(32'(pwdata[17:0]), SR_LO, SR_HI));
        REG_SYNC_MODE: sync_mode_q <= pwdata[0];
        REG_RUN_EN:    run_en_q    <= pwdata[0];
        REG_USER_EN:   user_en_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // free running step operands, settled from the registers
  always_ff @(posedge clk_i) begin
    prod_q <= {24'b0, tempo_q} * {14'b0, rmult_q};
    sr60_q <= {sr_q, 6'b0} - {4'b0, sr_q, 2'b0};
  end

  always_comb begin
    cnt_inc   = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
    high      = x_q > SYNC_HIGH_LVL;
    sync_rise = sync_mode_q & high & ~was_high_q;
    per_new   = (sync_rise && cnt_inc != '0) ? cnt_inc : per_q;
    cnt_new   = sync_rise ? '0 : cnt_inc;
    if (sync_mode_q) run = user_en_q & ~(per_new != '0 && cnt_new > per_new);
    else             run = run_en_q;
  end

  always_comb begin
    num_a = {rmult_q, {PHASE_BITS{1'b0}}};
    num_b = {prod_q, {PHASE_BITS{1'b0}}};
    if (per_new != '0) begin
      dividend = {num_a[PHASE_BITS+23:16], 10'b0};
      divisor  = DVW'(per_new);
    end else begin
      dividend = num_b[PHASE_BITS+37:20];
      divisor  = DVW'(sr60_q);
    end
    div_ctl.start    = (state_q == ST_EVAL) & run;
    div_ctl.short_op = per_new != '0;
  end

  tsgc_div #(
    .PHASE_BITS(PHASE_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .stat_o     (div_stat),
    .quot_o     (quot)
  );

  assign phase_sum = phase_q + quot;
  assign pw_cmp    = PHASE_BITS'(pw_q) << (PHASE_BITS - 16);
  assign push      = (state_q == ST_FIN) & (~out_valid_q | ~out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      cnt_q       <= '0;
      per_q       <= '0;
      was_high_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (tempo_wr) per_q <= '0;
      if (out_valid_q && !out_stall_i && !push) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          cnt_q <= cnt_new;
          if (!tempo_wr) per_q <= per_new;
          if (sync_mode_q) was_high_q <= high;
          if (sync_rise) phase_q <= '0;
          state_q <= run ? ST_DIV : ST_FIN;
        end
        ST_DIV: begin
          if (div_stat.done && !div_stat.busy) state_q <= ST_ADD;
        end
        ST_ADD: begin
          phase_q <= phase_sum;
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (push) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) x_q <= sync_sample_i;
    if (state_q == ST_EVAL) begin
      res_gate_q   <= 1'b0;
      res_active_q <= run;
      res_edge_q   <= sync_rise;
    end
    if (state_q == ST_ADD) res_gate_q <= phase_sum < pw_cmp;
    if (push) begin
      gate_q   <= res_gate_q;
      active_q <= res_active_q;
      edge_q   <= res_edge_q;
    end
  end

  assign in_stall_o     = state_q != ST_IDLE;
  assign out_valid_o    = out_valid_q;
  assign gate_out_o     = gate_q;
  assign clock_active_o = active_q;
  assign sync_edge_o    = edge_q;

endmodule

`default_nettype wire

/* sv/tsgc_checker.sv */
// port level checks of the tempo synced gate clock, bound to the top level
`default_nettype none

module tsgc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               gate_out_o,
  input logic               clock_active_o,
  input logic               sync_edge_o
);

  // a taken tick keeps the input stalled while it is worked on
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a word was taken");

  // a gate pulse only comes from a running clock
  a_gate_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && gate_out_o |-> clock_active_o)
    else $error("gate high while clock stopped");

  // a new result word appears only as the sequencer returns to idle
  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result word posted while tick still in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(gate_out_o) &&
      $stable(clock_active_o) && $stable(sync_edge_o))
    else $error("stalled output word changed");

endmodule

bind tempo_sync_gate_clock_core tsgc_checker u_tsgc_checker (.*);

`default_nettype wire

/* dv/tsgc_tb_pkg.sv */
// scoreboard for the tempo synced gate clock: tick predictor and expected word store
`timescale 1ns / 100ps

package tsgc_tb_pkg;
  import tsgc_pkg::*;

  typedef struct packed {
    logic gate;
    logic active;
    logic sync_edge;
  } tick_word_t;

  class gate_tick_board;
    logic [13:0] tempo;
    logic [23:0] rate_mult;
    logic [15:0] pulse_w;
    logic [17:0] sample_hz;
    logic        sync_on;
    logic        run_on;
    logic        user_on;
    logic [31:0] phase;
    logic [31:0] step;
    logic [31:0] ticks;
    logic [31:0] period;
    logic        was_high;
    tick_word_t  due_words[$];
    int unsigned errors;

    function new();
      tempo     = TEMPO_RST;
      rate_mult = RMULT_RST;
      pulse_w   = PW_RST;
      sample_hz = SR_RST;
      sync_on   = 1'b0;
      run_on    = 1'b1;
      user_on   = 1'b1;
      phase     = '0;
      step      = '0;
      ticks     = '0;
      period    = '0;
      was_high  = 1'b0;
      errors    = 0;
    endfunction

    function logic [31:0] bound_to(logic [31:0] v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // floor(num * 2^32 / den), kept to 32 fraction bits
    function logic [31:0] frac_ratio(logic [63:0] num, logic [63:0] den);
      logic [127:0] quo;
      quo = (128'(num) << 32) / 128'(den);
      return quo[31:0];
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_TEMPO: begin
          tempo  = 14'(bound_to(v & 32'h3FFF, TEMPO_LO, TEMPO_HI));
          period = '0;
        end
        REG_RATE_MULT: rate_mult = 24'(bound_to(v & 32'hFF_FFFF, RMULT_LO, RMULT_HI));
        REG_PULSE_W:   pulse_w   = 16'(bound_to(v & 32'hFFFF, PW_LO, PW_HI));
        REG_SAMPLE_HZ: sample_hz = 18'(bound_to(v & 32'h3_FFFF, SR_LO, SR_HI));
        REG_SYNC_MODE: sync_on   = v[0];
        REG_RUN_EN:    run_on    = v[0];
        REG_USER_EN:   user_on   = v[0];
        default: ;
      endcase
    endfunction

    function void take_sample(logic signed [15:0] s);
      logic       high;
      logic       rising;
      logic       run;
      tick_word_t w;
      rising = 1'b0;
      if (ticks != '1) ticks = ticks + 1;
      if (sync_on) begin
        high     = s > SYNC_HIGH_LVL;
        rising   = high && !was_high;
        was_high = high;
        if (rising) begin
          if (ticks != 0) period = ticks;
          ticks = '0;
          phase = '0;
        end
        run = user_on && !(period != 0 && ticks > period);
      end else begin
        run = run_on;
      end
      w.gate = 1'b0;
      if (run) begin
        if (period != 0) step = frac_ratio(64'(rate_mult), 64'(period) << 16);
        else step = frac_ratio(64'(tempo) * 64'(rate_mult), (64'(sample_hz) * 64'd60) << 20);
        phase  = phase + step;
        w.gate = phase < {pulse_w, 16'd0};
      end
      w.active    = run;
      w.sync_edge = rising;
      due_words.push_back(w);
    endfunction

    function void flag_field(string name, logic want, logic got);
      errors++;
      $display("%0t: %s mismatch, expected %0b, got %0b", $time, name, want, got);
    endfunction

    function void check_word(tick_word_t got);
      tick_word_t want;
      if (due_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got gate %0b active %0b edge %0b",
                 $time, got.gate, got.active, got.sync_edge);
        return;
      end
      want = due_words.pop_front();
      if (got.gate !== want.gate) flag_field("gate_out", want.gate, got.gate);
      if (got.active !== want.active) flag_field("clock_active", want.active, got.active);
      if (got.sync_edge !== want.sync_edge) flag_field("sync_edge", want.sync_edge, got.sync_edge);
    endfunction

    function int unsigned pending();
      return due_words.size();
    endfunction
  endclass

endpackage

/* dv/tb.sv */
// testbench top for the tempo synced gate clock: sample ticks, register writes, word checks
`timescale 1ns / 100ps

module tb;
  import tsgc_pkg::*;
  import tsgc_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RAND_PHASES  = 15;
  localparam int unsigned PHASE_WORDS  = 52;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam logic [2:0]  REG_UNUSED   = 3'd7;
  localparam logic signed [15:0] LVL_MAX = 16'sh7FFF;
  localparam logic signed [15:0] LVL_MIN = 16'sh8000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] sync_sample_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               gate_out_o;
  logic               clock_active_o;
  logic               sync_edge_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  gate_tick_board board;
  bit             tx_idle = 1'b1;
  bit             rx_idle = 1'b1;
  int unsigned    rx_wait = 0;
  int unsigned    cycles = 0;

  tempo_sync_gate_clock_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sync_sample_i  (sync_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .gate_out_o     (gate_out_o),
    .clock_active_o (clock_active_o),
    .sync_edge_o    (sync_edge_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // output side: check each word, then hold stall for a drawn number of valid cycles
  always @(posedge clk_i) begin : rx_side
    tick_word_t got;
    if (out_valid_o && !out_stall_i) begin
      got = {gate_out_o, clock_active_o, sync_edge_o};
      board.check_word(got);
      rx_wait = rx_idle ? $urandom_range(0, 6) : 0;
    end else if (out_valid_o && rx_wait != 0) begin
      rx_wait = rx_wait - 1;
    end
    out_stall_i <= (rx_wait != 0);
  end

  task automatic push_sample(input logic signed [15:0] s);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sync_sample_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    board.take_sample(s);
  endtask

  task automatic halt_input();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_reg(idx, v);
  endtask

  task automatic bus_idle();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      2: return $urandom();
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  function automatic logic [31:0] pick_flag(input int unsigned one_odds);
    return {31'($urandom()), $urandom_range(0, one_odds) != 0};
  endfunction

  function automatic logic signed [15:0] low_level();
    return 16'($urandom_range(0, 49152) - 32768);
  endfunction

  function automatic logic signed [15:0] high_level();
    return 16'($urandom_range(16385, 32767));
  endfunction

  task automatic shuffle_regs();
    if ($urandom_range(0, 2) == 0) write_reg(REG_TEMPO, pick_value(TEMPO_LO, TEMPO_HI));
    if ($urandom_range(0, 1) == 0) write_reg(REG_RATE_MULT, pick_value(RMULT_LO, RMULT_HI));
    if ($urandom_range(0, 1) == 0) write_reg(REG_PULSE_W, pick_value(PW_LO, PW_HI));
    if ($urandom_range(0, 1) == 0) write_reg(REG_SAMPLE_HZ, pick_value(SR_LO, SR_HI));
    write_reg(REG_SYNC_MODE, pick_flag(2));
    write_reg(REG_RUN_EN, pick_flag(4));
    write_reg(REG_USER_EN, pick_flag(4));
    bus_idle();
  endtask

  initial begin
    int unsigned sent;
    int unsigned p;
    int unsigned h;
    int unsigned k;
    int unsigned reps;
    board = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // free running at reset settings, input extremes
    push_sample(16'sh0000);
    push_sample(LVL_MIN);
    push_sample(LVL_MAX);
    push_sample(SYNC_HIGH_LVL);
    push_sample(SYNC_HIGH_LVL + 16'sd1);
    push_sample(-16'sd1);
    halt_input();
    wait_drained();

    // registers past both ends of their ranges, sample rate first at its lower bound
    write_reg(REG_TEMPO, 32'h3FFF);
    write_reg(REG_RATE_MULT, 32'hFFFF_FFFF);
    write_reg(REG_PULSE_W, 32'd0);
    write_reg(REG_SAMPLE_HZ, 32'd1);
    bus_idle();
    repeat (3) push_sample(16'sh0000);
    halt_input();
    wait_drained();
    write_reg(REG_TEMPO, 32'd0);
    write_reg(REG_RATE_MULT, 32'd0);
    write_reg(REG_PULSE_W, 32'hFFFF);
    write_reg(REG_SAMPLE_HZ, 32'h3_FFFF);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(REG_RUN_EN, 32'd0);
    bus_idle();
    repeat (2) push_sample(LVL_MAX);
    halt_input();
    wait_drained();
    write_reg(REG_RUN_EN, 32'd1);
    bus_idle();
    push_sample(LVL_MIN);
    halt_input();
    wait_drained();

    // sync: edges, threshold level, silence past the period
    write_reg(REG_RATE_MULT, 32'd65536);
    write_reg(REG_PULSE_W, 32'd32768);
    write_reg(REG_SYNC_MODE, 32'd1);
    bus_idle();
    push_sample(16'sh0000);
    push_sample(16'sd20000);
    push_sample(16'sd20000);
    push_sample(SYNC_HIGH_LVL);
    push_sample(LVL_MAX);
    repeat (4) push_sample(16'sh0000);
    push_sample(LVL_MAX);
    halt_input();
    wait_drained();

    // edge while user switch is off, then period kept after leaving sync mode
    write_reg(REG_USER_EN, 32'd0);
    bus_idle();
    push_sample(16'sh0000);
    push_sample(16'sd30000);
    halt_input();
    wait_drained();
    write_reg(REG_SYNC_MODE, 32'd0);
    write_reg(REG_USER_EN, 32'd1);
    bus_idle();
    repeat (2) push_sample(16'sh0000);
    halt_input();
    wait_drained();
    write_reg(REG_TEMPO, 32'd1920);
    bus_idle();
    push_sample(16'sh0000);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      halt_input();
      wait_drained();
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      shuffle_regs();
      sent = 0;
      while (sent < PHASE_WORDS) begin
        case ($urandom_range(0, 9))
          7: begin
            k = $urandom_range(10, 60);
            repeat (k) push_sample(low_level());
            sent += k;
          end
          8, 9: begin
            k = $urandom_range(1, 10);
            repeat (k) push_sample(16'($urandom()));
            sent += k;
          end
          default: begin
            p    = $urandom_range(2, 24);
            h    = $urandom_range(1, p - 1);
            reps = $urandom_range(1, 4);
            repeat (reps) begin
              for (int i = 0; i < p; i++) push_sample(i < h ? high_level() : low_level());
            end
            sent += p * reps;
          end
        endcase
      end
    end

    halt_input();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
